FILE: rtl/ssp_pkg.sv
// Shared definitions for the single-source shortest path unit.
// Holds field widths, request and register codes and the relax datapath structs.
// No dependencies.
package ssp_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 1024;

    // Field widths fixed by the interface.
    localparam int VERTEX_W   = 6;
    localparam int COST_W     = 16;
    localparam int DIST_W     = 32;
    localparam int REQ_W      = 2;
    localparam int VC_W       = 7;
    localparam int VX_W       = 8;
    localparam int EDGE_W     = 2 * VERTEX_W + COST_W;
    localparam int DENTRY_W   = DIST_W + 1;

    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [REQ_W-1:0] REQ_ADD_EDGE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 2'd1;

    localparam logic [VC_W-1:0]     VERTEX_COUNT_RESET  = 7'd64;
    localparam logic [VERTEX_W-1:0] SOURCE_VERTEX_RESET = 6'd0;

    typedef struct packed {
        logic [DIST_W-1:0] tail_dist;
        logic [COST_W-1:0] cost;
        logic [DIST_W-1:0] head_dist;
        logic              head_reached;
    } relax_in_t;

    typedef struct packed {
        logic              update;
        logic [DIST_W-1:0] cand;
    } relax_out_t;

endpackage

FILE: rtl/ssp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ssp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ssp_relax_alu.sv
// Relaxation unit: candidate distance and signed improvement test for one edge.
// Depends on ssp_pkg.
module ssp_relax_alu (
    input  ssp_pkg::relax_in_t  relax_in,
    output ssp_pkg::relax_out_t relax_out
);

    logic [ssp_pkg::DIST_W-1:0] cand;

    assign cand = relax_in.tail_dist
                + {{(ssp_pkg::DIST_W - ssp_pkg::COST_W){relax_in.cost[ssp_pkg::COST_W-1]}},
                   relax_in.cost};

    // A head that has never been reached takes any candidate.
    assign relax_out.cand   = cand;
    assign relax_out.update = !relax_in.head_reached
                            || ($signed(cand) < $signed(relax_in.head_dist));

endmodule

FILE: rtl/single_source_shortest_path_unit.sv
// Bellman-Ford shortest path unit: edge store, distance store and a relaxation sequencer.
// Depends on ssp_pkg, ssp_ram and ssp_relax_alu. Add-edge and clear beats are handled in S_IDLE.
// Run: a sweep rewrites the distance store; each pass then reads every vertex and, for a reached
// tail with stored edges, reads every stored edge and relaxes each owned edge whose head is in use.
// At most nv passes; results then go out one per vertex, each held until m_tready.
// Reset clears the edge count and sets vertex_count 64, source_vertex 0; RAMs are not cleared.
module single_source_shortest_path_unit #(
    parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = ssp_pkg::MAX_EDGES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input beats.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // edge_from [5:0], edge_to [11:6], edge_cost [27:12], zero fill above
    input  logic [ssp_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type [1:0], zero fill above
    input  logic [ssp_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result beats.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // vertex_index [5:0], distance [37:6], zero fill above
    output logic [ssp_pkg::M_TDATA_W-1:0]    m_tdata,
    // reachable [0], negative_cycle [1], zero fill above
    output logic [ssp_pkg::M_TUSER_W-1:0]    m_tuser,
    // last_vertex
    output logic                             m_tlast,
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int DAW = $clog2(MAX_VERTICES);
    localparam int NVW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLEAR = 10'b0000000010,
        S_VRD   = 10'b0000000100,
        S_VCHK  = 10'b0000001000,
        S_ERD   = 10'b0000010000,
        S_EDEC  = 10'b0000100000,
        S_CMP   = 10'b0001000000,
        S_ORD   = 10'b0010000000,
        S_OLD   = 10'b0100000000,
        S_OHOLD = 10'b1000000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [ssp_pkg::VC_W-1:0]       vc_reg;
    logic [ssp_pkg::VERTEX_W-1:0]   src_reg;
    logic [ECW-1:0]                 count_reg, count_next;
    logic [ECW-1:0]                 e_reg, e_next;
    logic [NVW-1:0]                 v_reg, v_next;
    logic [NVW-1:0]                 pass_reg, pass_next;
    logic [NVW-1:0]                 nv_reg, nv_next;
    logic                           upd_reg, upd_next;
    logic                           negc_reg, negc_next;
    logic [ssp_pkg::DIST_W-1:0]     dv_reg, dv_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [ssp_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [ssp_pkg::M_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;
    logic                           m_tlast_reg, m_tlast_next;

    logic                           edge_we;
    logic [ssp_pkg::EDGE_W-1:0]     edge_wdata, edge_rdata;
    logic                           dist_we;
    logic [DAW-1:0]                 dist_waddr, dist_raddr;
    logic [ssp_pkg::DENTRY_W-1:0]   dist_wdata, dist_rdata;

    logic [ssp_pkg::VERTEX_W-1:0]   e_from, e_to;
    logic [ssp_pkg::COST_W-1:0]     e_cost;
    ssp_pkg::relax_in_t             relax_in;
    ssp_pkg::relax_out_t            relax_out;

    logic                           in_beat;
    logic [ssp_pkg::REQ_W-1:0]      req;
    logic [NVW-1:0]                 nv_cfg;
    logic                           v_last, pass_last, e_more, edge_ok;
    logic                           adv_vertex, adv_edge, upd_now;

    assign e_from = edge_rdata[ssp_pkg::VERTEX_W-1:0];
    assign e_to   = edge_rdata[2*ssp_pkg::VERTEX_W-1:ssp_pkg::VERTEX_W];
    assign e_cost = edge_rdata[ssp_pkg::EDGE_W-1:2*ssp_pkg::VERTEX_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;
    assign req       = s_tuser[ssp_pkg::REQ_W-1:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Vertex count is clamped into one to MAX_VERTICES.
    always_comb
    begin
        if (vc_reg == '0)
        begin
            nv_cfg = NVW'(1);
        end
        else if (ssp_pkg::VX_W'(vc_reg) > ssp_pkg::VX_W'(MAX_VERTICES))
        begin
            nv_cfg = NVW'(MAX_VERTICES);
        end
        else
        begin
            nv_cfg = NVW'(vc_reg);
        end
    end

    assign v_last    = ((v_reg + NVW'(1)) == nv_reg);
    assign pass_last = ((pass_reg + NVW'(1)) == nv_reg);
    assign e_more    = ((e_reg + ECW'(1)) < count_reg);
    assign edge_ok   = (ssp_pkg::VX_W'(e_from) == ssp_pkg::VX_W'(v_reg))
                    && (ssp_pkg::VX_W'(e_to) < ssp_pkg::VX_W'(nv_reg));

    assign relax_in.tail_dist    = dv_reg;
    assign relax_in.cost         = e_cost;
    assign relax_in.head_dist    = dist_rdata[ssp_pkg::DIST_W-1:0];
    assign relax_in.head_reached = dist_rdata[ssp_pkg::DIST_W];

    ssp_relax_alu u_relax (
        .relax_in  (relax_in),
        .relax_out (relax_out)
    );

    assign edge_we    = in_beat && (req == ssp_pkg::REQ_ADD_EDGE)
                     && (count_reg < ECW'(MAX_EDGES));
    assign edge_wdata = s_tdata[ssp_pkg::EDGE_W-1:0];

    ssp_ram #(
        .WIDTH (ssp_pkg::EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (count_reg[EAW-1:0]),
        .wdata (edge_wdata),
        .raddr (e_reg[EAW-1:0]),
        .rdata (edge_rdata)
    );

    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = v_reg[DAW-1:0];
        dist_wdata = {(ssp_pkg::VX_W'(src_reg) == ssp_pkg::VX_W'(v_reg)),
                      {ssp_pkg::DIST_W{1'b0}}};
        dist_raddr = v_reg[DAW-1:0];
        if (state_reg == S_CLEAR)
        begin
            dist_we = 1'b1;
        end
        if (state_reg == S_EDEC)
        begin
            dist_raddr = e_to[DAW-1:0];
        end
        if ((state_reg == S_CMP) && relax_out.update)
        begin
            dist_we    = 1'b1;
            dist_waddr = e_to[DAW-1:0];
            dist_wdata = {1'b1, relax_out.cand};
        end
    end

    ssp_ram #(
        .WIDTH (ssp_pkg::DENTRY_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    assign upd_now = upd_reg || ((state_reg == S_CMP) && relax_out.update);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        e_next        = e_reg;
        v_next        = v_reg;
        pass_next     = pass_reg;
        nv_next       = nv_reg;
        upd_next      = upd_reg;
        negc_next     = negc_reg;
        dv_next       = dv_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        adv_vertex    = 1'b0;
        adv_edge      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    case (req)
                        ssp_pkg::REQ_ADD_EDGE:
                        begin
                            if (edge_we)
                            begin
                                count_next = count_reg + ECW'(1);
                            end
                        end
                        ssp_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ssp_pkg::REQ_RUN:
                        begin
                            nv_next    = nv_cfg;
                            v_next     = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (v_last)
                begin
                    v_next     = '0;
                    pass_next  = '0;
                    upd_next   = 1'b0;
                    state_next = S_VRD;
                end
                else
                begin
                    v_next = v_reg + NVW'(1);
                end
            end
            S_VRD:
            begin
                state_next = S_VCHK;
            end
            S_VCHK:
            begin
                dv_next = dist_rdata[ssp_pkg::DIST_W-1:0];
                if (dist_rdata[ssp_pkg::DIST_W] && (count_reg != '0))
                begin
                    e_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    adv_vertex = 1'b1;
                end
            end
            S_ERD:
            begin
                state_next = S_EDEC;
            end
            S_EDEC:
            begin
                if (edge_ok)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    adv_edge = 1'b1;
                end
            end
            S_CMP:
            begin
                if (relax_out.update)
                begin
                    upd_next = 1'b1;
                    // A self loop moves the tail distance used by later edges.
                    if (ssp_pkg::VX_W'(e_to) == ssp_pkg::VX_W'(v_reg))
                    begin
                        dv_next = relax_out.cand;
                    end
                end
                adv_edge = 1'b1;
            end
            S_ORD:
            begin
                state_next = S_OLD;
            end
            S_OLD:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {{(ssp_pkg::M_TDATA_W - ssp_pkg::DIST_W - ssp_pkg::VERTEX_W){1'b0}},
                                 (dist_rdata[ssp_pkg::DIST_W] ? dist_rdata[ssp_pkg::DIST_W-1:0]
                                                              : {ssp_pkg::DIST_W{1'b0}}),
                                 ssp_pkg::VERTEX_W'(v_reg)};
                m_tuser_next  = {{(ssp_pkg::M_TUSER_W - 2){1'b0}}, negc_reg,
                                 dist_rdata[ssp_pkg::DIST_W]};
                m_tlast_next  = v_last;
                state_next    = S_OHOLD;
            end
            S_OHOLD:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (v_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        v_next     = v_reg + NVW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv_edge)
        begin
            if (e_more)
            begin
                e_next     = e_reg + ECW'(1);
                state_next = S_ERD;
            end
            else
            begin
                adv_vertex = 1'b1;
            end
        end

        // End of a tail vertex: next vertex, next pass, or on to the results.
        if (adv_vertex)
        begin
            if (!v_last)
            begin
                v_next     = v_reg + NVW'(1);
                state_next = S_VRD;
            end
            else if (upd_now && !pass_last)
            begin
                v_next     = '0;
                pass_next  = pass_reg + NVW'(1);
                upd_next   = 1'b0;
                state_next = S_VRD;
            end
            else
            begin
                v_next     = '0;
                negc_next  = upd_now;
                state_next = S_ORD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            vc_reg       <= ssp_pkg::VERTEX_COUNT_RESET;
            src_reg      <= ssp_pkg::SOURCE_VERTEX_RESET;
            count_reg    <= '0;
            e_reg        <= '0;
            v_reg        <= '0;
            pass_reg     <= '0;
            nv_reg       <= NVW'(1);
            upd_reg      <= 1'b0;
            negc_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            e_reg        <= e_next;
            v_reg        <= v_next;
            pass_reg     <= pass_next;
            nv_reg       <= nv_next;
            upd_reg      <= upd_next;
            negc_reg     <= negc_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ssp_pkg::REG_VERTEX_COUNT)
                begin
                    vc_reg <= cfg_data;
                end
                else if (cfg_index == ssp_pkg::REG_SOURCE_VERTEX)
                begin
                    src_reg <= cfg_data[ssp_pkg::VERTEX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg      <= dv_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VRD || state_reg == S_CMP) |-> (pass_reg < nv_reg))
        else $error("relaxation ran past the pass limit");

    a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("unit not idle after the final result");

endmodule
